FILE: rtl/contact_pair_finder_defines.svh
// ---------------------------------------------------------------------------
// Contact pair finder assertion macros
// Shared property forms for the checker of the contact pair finder.
// ---------------------------------------------------------------------------
`ifndef CONTACT_PAIR_FINDER_DEFINES_SVH
`define CONTACT_PAIR_FINDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("contact pair finder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("contact pair finder: next-cycle check failed");

`endif

FILE: rtl/cpf_pkg.sv
// ---------------------------------------------------------------------------
// Contact pair finder package
// Field widths, word types, stored entry type and controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

  localparam int unsigned PARTICLES_DEF = 64;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned THR_W     = 52;
  localparam int unsigned DIFF_W    = 25;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned SQ_W      = 48;
  localparam int unsigned SUM_W     = 50;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned CNT_OUT_W = 11;

  localparam logic [OUT_IDX_W-1:0] MAX_PAIRS_OUT = 6'd63;
  localparam logic [CNT_OUT_W-1:0] COUNT_MAX     = 11'd2047;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [ID_W-1:0]    molecule_id;
    logic                      last_particle;
  } cpf_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] earlier_index;
    logic [OUT_IDX_W-1:0] later_index;
    logic                 is_pair;
    logic [CNT_OUT_W-1:0] pair_count;
    logic                 set_done;
    logic                 overflow;
    logic                 last_of_run;
  } cpf_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [ID_W-1:0]    id;
  } cpf_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STATUS
  } cpf_state_e;

endpackage

`default_nettype wire

FILE: rtl/contact_pair_finder.sv
// The status word of an item follows the scan of the particles stored in the current
// set; one stored particle is read per cycle, and a pair word follows the read of its
// stored particle through the RAM read register, the distance pipeline and the result
// register. The next item can be accepted once the status word is given. A dropped or
// first particle gives its status word without a scan.
// The receiver cannot stall. Reset empties the set, clears the count and zeroes the threshold.
// ---------------------------------------------------------------------------
// Contact pair finder
// Compares each new particle, unless the set is full, with the stored particles of its set and
// reports close pairs of different molecules, then a status word.
// ---------------------------------------------------------------------------
`default_nettype none

module contact_pair_finder #(
  parameter int unsigned PARTICLES = cpf_pkg::PARTICLES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  cpf_pkg::cpf_in_t          item_i,
  output logic                      result_valid_o,
  output cpf_pkg::cpf_out_t         result_o,
  input  logic                      cfg_we_i,
  input  logic [cpf_pkg::THR_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(PARTICLES);
  localparam int unsigned CNT_W = $clog2(PARTICLES + 1);

  cpf_pkg::cpf_state_e state_q, state_d;

  cpf_pkg::cpf_in_t             cur_q;
  logic [IDX_W-1:0]             cur_n_q;
  logic                         ovf_q;
  logic [IDX_W-1:0]             scan_q;
  logic                         rd_vld_q;
  logic [IDX_W-1:0]             rd_idx_q;
  logic [CNT_W-1:0]             count_q;
  logic [cpf_pkg::CNT_OUT_W-1:0] total_q;
  logic [cpf_pkg::OUT_IDX_W-1:0] k_q;
  logic [cpf_pkg::THR_W-1:0]    thr_q;
  cpf_pkg::cpf_out_t            res_q;
  logic                         res_vld_q;

  logic                         accept, full, empty, rd_en, scan_end;
  logic                         hit_vld, active;
  logic [IDX_W-1:0]             hit_idx;
  logic [cpf_pkg::CNT_OUT_W-1:0] total_inc;
  logic [IDX_W+cpf_pkg::OUT_IDX_W-1:0] ext_e, ext_l;
  cpf_pkg::cpf_entry_t          wr_entry, rd_entry, probe;

  assign full     = count_q == CNT_W'(PARTICLES);
  assign empty    = count_q == '0;
  assign scan_end = scan_q == cur_n_q - IDX_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpf_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (full || empty) ? cpf_pkg::ST_STATUS : cpf_pkg::ST_SCAN;
        end
      end
      cpf_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = cpf_pkg::ST_DRAIN;
        end
      end
      cpf_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !active) begin
          state_d = cpf_pkg::ST_STATUS;
        end
      end
      cpf_pkg::ST_STATUS: begin
        state_d = cpf_pkg::ST_IDLE;
      end
      default: begin
        state_d = cpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy   = state_q != cpf_pkg::ST_IDLE;
    accept = start && !busy;
    rd_en  = state_q == cpf_pkg::ST_SCAN;
  end

  assign wr_entry  = '{x: item_i.pos_x, y: item_i.pos_y, z: item_i.pos_z,
                       id: item_i.molecule_id};
  assign probe     = '{x: cur_q.pos_x, y: cur_q.pos_y, z: cur_q.pos_z,
                       id: cur_q.molecule_id};
  assign total_inc = (total_q == cpf_pkg::COUNT_MAX) ? total_q
                                                     : total_q + 1'b1;
  assign ext_e     = {{cpf_pkg::OUT_IDX_W{1'b0}}, hit_idx};
  assign ext_l     = {{cpf_pkg::OUT_IDX_W{1'b0}}, cur_n_q};

  cpf_ram #(
    .WIDTH ($bits(cpf_pkg::cpf_entry_t)),
    .DEPTH (PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (scan_q),
    .rdata_o (rd_entry)
  );

  cpf_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (rd_vld_q),
    .idx_i     (rd_idx_q),
    .entry_i   (rd_entry),
    .probe_i   (probe),
    .thr_i     (thr_q),
    .hit_vld_o (hit_vld),
    .hit_idx_o (hit_idx),
    .active_o  (active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpf_pkg::ST_IDLE;
      rd_vld_q  <= 1'b0;
      count_q   <= '0;
      total_q   <= '0;
      k_q       <= '0;
      thr_q     <= '0;
      res_vld_q <= 1'b0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en;
      res_vld_q <= 1'b0;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        scan_q <= '0;
        k_q    <= '0;
      end else if (rd_en) begin
        scan_q <= scan_q + 1'b1;
      end
      if (hit_vld) begin
        total_q <= total_inc;
        if (k_q != cpf_pkg::MAX_PAIRS_OUT) begin
          k_q       <= k_q + 1'b1;
          res_vld_q <= 1'b1;
        end
      end
      if (state_q == cpf_pkg::ST_STATUS) begin
        res_vld_q <= 1'b1;
        if (cur_q.last_particle) begin
          count_q <= '0;
          total_q <= '0;
        end else if (!ovf_q) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
    if (accept) begin
      cur_q   <= item_i;
      cur_n_q <= count_q[IDX_W-1:0];
      ovf_q   <= full;
    end
    if (hit_vld) begin
      res_q <= '{earlier_index: ext_e[cpf_pkg::OUT_IDX_W-1:0],
                 later_index:   ext_l[cpf_pkg::OUT_IDX_W-1:0],
                 is_pair:       1'b1,
                 pair_count:    total_inc,
                 set_done:      1'b0,
                 overflow:      1'b0,
                 last_of_run:   1'b0};
    end
    if (state_q == cpf_pkg::ST_STATUS) begin
      res_q <= '{earlier_index: '0,
                 later_index:   '0,
                 is_pair:       1'b0,
                 pair_count:    total_q,
                 set_done:      cur_q.last_particle,
                 overflow:      ovf_q,
                 last_of_run:   1'b1};
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

FILE: rtl/cpf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/cpf_dist.sv
// ---------------------------------------------------------------------------
// Contact distance pipeline
// Three stages: absolute differences, squares, sum and threshold compare.
// ---------------------------------------------------------------------------
`default_nettype none

module cpf_dist #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [IDX_W-1:0]            idx_i,
  input  cpf_pkg::cpf_entry_t         entry_i,
  input  cpf_pkg::cpf_entry_t         probe_i,
  input  logic [cpf_pkg::THR_W-1:0]   thr_i,
  output logic                        hit_vld_o,
  output logic [IDX_W-1:0]            hit_idx_o,
  output logic                        active_o
);

  logic [cpf_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [cpf_pkg::MAG_W-1:0]  mx, my, mz;
  logic [cpf_pkg::SUM_W-1:0]  sum;

  logic                        s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0]            s1_idx_q, s2_idx_q, s3_idx_q;
  logic                        s1_ne_q, s2_ne_q, s3_hit_q;
  logic [cpf_pkg::MAG_W-1:0]   s1_mx_q, s1_my_q, s1_mz_q;
  logic [cpf_pkg::SQ_W-1:0]    s2_sx_q, s2_sy_q, s2_sz_q;

  always_comb begin
    dx = {entry_i.x[cpf_pkg::COORD_W-1], entry_i.x} - {probe_i.x[cpf_pkg::COORD_W-1], probe_i.x};
    dy = {entry_i.y[cpf_pkg::COORD_W-1], entry_i.y} - {probe_i.y[cpf_pkg::COORD_W-1], probe_i.y};
    dz = {entry_i.z[cpf_pkg::COORD_W-1], entry_i.z} - {probe_i.z[cpf_pkg::COORD_W-1], probe_i.z};
    mx = dx[cpf_pkg::DIFF_W-1] ? cpf_pkg::MAG_W'(~dx + 1'b1) : cpf_pkg::MAG_W'(dx);
    my = dy[cpf_pkg::DIFF_W-1] ? cpf_pkg::MAG_W'(~dy + 1'b1) : cpf_pkg::MAG_W'(dy);
    mz = dz[cpf_pkg::DIFF_W-1] ? cpf_pkg::MAG_W'(~dz + 1'b1) : cpf_pkg::MAG_W'(dz);
    sum = cpf_pkg::SUM_W'(s2_sx_q) + cpf_pkg::SUM_W'(s2_sy_q) + cpf_pkg::SUM_W'(s2_sz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    s1_ne_q  <= entry_i.id != probe_i.id;
    s1_mx_q  <= mx;
    s1_my_q  <= my;
    s1_mz_q  <= mz;
    s2_idx_q <= s1_idx_q;
    s2_ne_q  <= s1_ne_q;
    s2_sx_q  <= cpf_pkg::SQ_W'(s1_mx_q) * cpf_pkg::SQ_W'(s1_mx_q);
    s2_sy_q  <= cpf_pkg::SQ_W'(s1_my_q) * cpf_pkg::SQ_W'(s1_my_q);
    s2_sz_q  <= cpf_pkg::SQ_W'(s1_mz_q) * cpf_pkg::SQ_W'(s1_mz_q);
    s3_idx_q <= s2_idx_q;
    s3_hit_q <= s2_ne_q && (cpf_pkg::THR_W'(sum) < thr_i);
  end

  assign hit_vld_o = s3_vld_q && s3_hit_q;
  assign hit_idx_o = s3_idx_q;
  assign active_o  = s1_vld_q || s2_vld_q || s3_vld_q;

endmodule

`default_nettype wire

FILE: rtl/cpf_checker.sv
// ---------------------------------------------------------------------------
// Contact pair finder checker
// Port-level checks on the start/busy handshake and the result words.
// ---------------------------------------------------------------------------
`default_nettype none

`include "contact_pair_finder_defines.svh"

module cpf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input cpf_pkg::cpf_out_t result_o
);

  `CPF_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `CPF_ASSERT_SAME(a_pair_busy, clk_i, rst_ni, result_valid_o && result_o.is_pair, busy)
  `CPF_ASSERT_SAME(a_pair_flags, clk_i, rst_ni, result_valid_o && result_o.is_pair, !result_o.set_done && !result_o.overflow && !result_o.last_of_run)
  `CPF_ASSERT_SAME(a_status_word, clk_i, rst_ni, result_valid_o && !result_o.is_pair, !busy && result_o.last_of_run && result_o.earlier_index == '0 && result_o.later_index == '0)

endmodule

bind contact_pair_finder cpf_checker u_cpf_checker (.*);

`default_nettype wire
